// File: sv/fir21s_pkg.sv
// Shared constants, types and coefficient tables for the selectable 21-tap FIR filter.
// Depends on nothing; every other file of the block imports it.
package fir21s_pkg;

  // Block dimensions.
  localparam int TAPS           = 21;
  localparam int SAMPLE_BITS    = 12;
  localparam int COEF_FRAC_BITS = 14;

  // Coefficient tables are stored as Q.14 integers.
  localparam int ROM_TAPS = 21;
  localparam int ROM_FRAC = 14;

  localparam int TAP_W      = $clog2(TAPS);
  localparam int SCALE_UP   = (COEF_FRAC_BITS >= ROM_FRAC) ? COEF_FRAC_BITS - ROM_FRAC : 0;
  localparam int SCALE_DN   = (COEF_FRAC_BITS < ROM_FRAC) ? ROM_FRAC - COEF_FRAC_BITS : 0;
  localparam int ROUND_HALF = (SCALE_DN > 0) ? (1 << (SCALE_DN - 1)) : 0;
  localparam int COEF_W     = 17 + SCALE_UP;
  localparam int PROD_W     = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_RAW_W  = PROD_W + TAP_W;
  localparam int FILT_W     = 31;
  localparam int ACC_W      = (ACC_RAW_W > FILT_W) ? ACC_RAW_W : FILT_W + 1;
  localparam int SET_W      = 2;

  // Duty computation: sample * 333 / 4095, where 4095 = 2^12 - 1.
  localparam int DUTY_W        = 9;
  localparam int DUTY_MUL      = 333;
  localparam int DUTY_MUL_W    = 9;
  localparam int DUTY_DIV      = 4095;
  localparam int DUTY_DIV_BITS = 12;
  localparam int DUTY_MAX      = 511;
  localparam int DUTY_PROD_W   = SAMPLE_BITS + DUTY_MUL_W;
  localparam int DUTY_Q_W      = DUTY_PROD_W - DUTY_DIV_BITS;
  localparam int DUTY_QX_W     = (DUTY_Q_W + 1 > DUTY_W) ? DUTY_Q_W + 1 : DUTY_W;
  localparam int DUTY_R_W      = ((DUTY_Q_W > DUTY_DIV_BITS) ? DUTY_Q_W : DUTY_DIV_BITS) + 2;

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [SET_W-1:0] {
    SET_INITIAL    = 2'd0,
    SET_HIGHPASS   = 2'd1,
    SET_BANDPASS   = 2'd2,
    SET_BANDREJECT = 2'd3
  } coef_set_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  localparam int ROM_INITIAL [ROM_TAPS] = '{
    0, -118, -371, -765, -1296, -1944, -2679, -3463, -4247, -4979, 56106,
    -4979, -4247, -3463, -2679, -1944, -1296, -765, -371, -118, 0
  };
  localparam int ROM_HIGHPASS [ROM_TAPS] = '{
    0, 0, 0, 0, 0, -5, -44, -213, -635, -1205, 14895,
    -1205, -635, -213, -44, -5, 0, 0, 0, 0, 0
  };
  localparam int ROM_BANDREJECT [ROM_TAPS] = '{
    0, 3, 27, 102, 268, 561, 982, 1488, 1981, 2344, 2478,
    2344, 1981, 1488, 982, 561, 268, 102, 27, 3, 0
  };

  // Coefficient of one tap, rescaled to COEF_FRAC_BITS fraction bits.
  // Scaling down rounds to nearest with ties away from zero.
  function automatic coef_t coef_at(input logic [SET_W-1:0] set,
                                    input logic [TAP_W-1:0] k);
    int v;
    int mag;
    v = 0;
    if (int'(k) < ROM_TAPS) begin
      unique case (coef_set_t'(set)) inside
        SET_HIGHPASS:              v = ROM_HIGHPASS[k];
        SET_BANDREJECT:            v = ROM_BANDREJECT[k];
        SET_INITIAL, SET_BANDPASS: v = ROM_INITIAL[k];
        default:                   v = ROM_INITIAL[k];
      endcase
    end
    if (SCALE_DN == 0) begin
      v = v <<< SCALE_UP;
    end else begin
      mag = (v < 0) ? -v : v;
      mag = (mag + ROUND_HALF) >>> SCALE_DN;
      v = (v < 0) ? -mag : mag;
    end
    return COEF_W'(v);
  endfunction

endpackage

// File: sv/fir21s_sample_if.sv
// Sample request channel: valid/ready handshake carrying one converter sample.
// Depends on fir21s_pkg.
interface fir21s_sample_if;
  import fir21s_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: sv/fir21s_result_if.sv
// Result request channel: valid/ready handshake carrying the filter sum and the duty value.
// Depends on fir21s_pkg.
interface fir21s_result_if;
  import fir21s_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [FILT_W-1:0] filtered;
  logic [DUTY_W-1:0]        pwm_duty;

  modport source (output valid, output filtered, output pwm_duty, input ready);
  modport sink (input valid, input filtered, input pwm_duty, output ready);
endinterface

// File: sv/fir21s_setting_if.sv
// Configuration write channel: valid/ready handshake carrying the coefficient set select.
// Depends on fir21s_pkg.
interface fir21s_setting_if;
  import fir21s_pkg::*;

  logic             valid;
  logic             ready;
  logic [SET_W-1:0] coefficient_set;

  modport source (output valid, output coefficient_set, input ready);
  modport sink (input valid, input coefficient_set, output ready);
endinterface

// File: sv/fir21s_cell.sv
// One cell of the sample window chain: holds one sample and loads its neighbor's value.
// Depends on fir21s_pkg.
module fir21s_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  fir21s_pkg::sample_t d,
  output fir21s_pkg::sample_t q
);
  import fir21s_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule

// File: sv/fir21s_mac.sv
// Shared multiply-accumulate unit with its coefficient lookup.
// Depends on fir21s_pkg; a register sits between the multiplier and the adder.
module fir21s_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  fir21s_pkg::mac_ctrl_t           ctrl,
  input  logic [fir21s_pkg::SET_W-1:0]    set,
  input  logic [fir21s_pkg::TAP_W-1:0]    tap,
  input  fir21s_pkg::sample_t             x,
  output logic signed [fir21s_pkg::ACC_W-1:0] acc
);
  import fir21s_pkg::*;

  coef_t                    coef;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  assign coef = coef_at(set, tap);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef) * $signed({1'b0, x});
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end
endmodule

// File: sv/fir_filter_21tap_selectable.sv
// Top level of the selectable 21-tap direct-form FIR filter with PWM duty output.
// Depends on fir21s_pkg, the three channel interfaces, fir21s_cell and fir21s_mac.
//
//   Channel   Modport  Payload                         Meaning
//   samples   sink     sample[11:0]                    converter sample in
//   results   source   filtered[30:0], pwm_duty[8:0]   FIR sum (Q.14) and PWM duty out
//   setting   sink     coefficient_set[1:0]            coefficient table select
//
// Each sample passes these states in order: idle takes the request, run rotates
// the window chain once past the single shared multiplier, flush drains the
// product register into the accumulator, and emit loads the output register
// and shifts the new sample into the window.
// Reset (synchronous, active high) zeroes the window, selects the initial
// coefficient table and empties the output register. A stalled result holds
// in the output register; the next sample is taken and filtered meanwhile, and
// only the final load step waits for the output register to drain.
module fir_filter_21tap_selectable (
  input logic           clk,
  input logic           rst,
  fir21s_sample_if.sink samples,
  fir21s_result_if.source results,
  fir21s_setting_if.sink setting
);
  import fir21s_pkg::*;

  localparam logic signed [ACC_W-1:0] SUM_HI = ACC_W'({(FILT_W - 1){1'b1}});
  localparam logic signed [ACC_W-1:0] SUM_LO = -SUM_HI - ACC_W'(1);

  state_t state;
  state_t state_next;

  logic [TAP_W-1:0] tap_cnt;
  logic [SET_W-1:0] coef_set;
  sample_t          sample_hold;
  logic             out_valid;

  logic             accept;
  logic             emit_load;
  logic             shift;
  mac_ctrl_t        mac_ctrl;
  sample_t          win [TAPS];
  sample_t          head_in;
  logic [TAP_W-1:0] tap_idx;

  logic signed [ACC_W-1:0]  acc;
  logic signed [FILT_W-1:0] filt_sat;

  logic [DUTY_PROD_W-1:0] duty_prod;
  logic [DUTY_QX_W-1:0]   q0, q1, q2;
  logic [DUTY_R_W-1:0]    r0, r1;
  logic [DUTY_W-1:0]      duty_val;

  // Config always writable; the user must write it only while idle (not enforced).
  assign setting.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_set <= SET_INITIAL;
    end else if (setting.valid) begin
      coef_set <= setting.coefficient_set;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (samples.valid) state_next = ST_RUN;
      ST_RUN:   if (tap_cnt == TAP_W'(TAPS - 1)) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_EMIT;
      ST_EMIT:  if (!out_valid || results.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    samples.ready  = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.issue = 1'b0;
    emit_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        samples.ready  = 1'b1;
        mac_ctrl.clear = samples.valid;
      end
      ST_RUN: begin
        mac_ctrl.issue = 1'b1;
      end
      ST_FLUSH: begin
      end
      ST_EMIT: begin
        emit_load = !out_valid || results.ready;
      end
      default: begin
      end
    endcase
  end

  assign accept = samples.valid && samples.ready;

  // Tap counter steps once per rotation cycle and wraps after the last tap.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_cnt <= '0;
    end else if (state == ST_RUN) begin
      tap_cnt <= (tap_cnt == TAP_W'(TAPS - 1)) ? '0 : tap_cnt + TAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_hold <= samples.sample;
    end
  end

  // Window chain. While running, the oldest sample is fed back to the head so
  // that after a full rotation the window stands as before. On the load step
  // the new sample enters at the head and the oldest one falls off the end.
  assign shift   = (state == ST_RUN) || emit_load;
  assign head_in = (state == ST_RUN) ? win[TAPS-1] : sample_hold;

  generate
    for (genvar i = 0; i < TAPS; i++) begin : g_cell
      if (i == 0) begin : g_head
        fir21s_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (head_in),
          .q     (win[i])
        );
      end else begin : g_body
        fir21s_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (win[i-1]),
          .q     (win[i])
        );
      end
    end
  endgenerate

  // After j rotations the tail holds the sample of tap TAPS-1-j.
  assign tap_idx = TAP_W'(TAPS - 1) - tap_cnt;

  fir21s_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .set  (coef_set),
    .tap  (tap_idx),
    .x    (win[TAPS-1]),
    .acc  (acc)
  );

  // Clamp the sum into the 31-bit result range.
  always_comb begin
    if (acc > SUM_HI) begin
      filt_sat = SUM_HI[FILT_W-1:0];
    end else if (acc < SUM_LO) begin
      filt_sat = SUM_LO[FILT_W-1:0];
    end else begin
      filt_sat = acc[FILT_W-1:0];
    end
  end

  // Duty: divide by 2^12 - 1 as a shift, then fix the remainder. The quotient
  // estimate x >> 12 leaves a remainder (x mod 4096) + q, which stays below
  // three times the divisor, so two conditional subtractions finish the job.
  always_comb begin
    duty_prod = DUTY_PROD_W'(sample_hold) * DUTY_PROD_W'(DUTY_MUL);
    q0 = DUTY_QX_W'(duty_prod[DUTY_PROD_W-1:DUTY_DIV_BITS]);
    r0 = DUTY_R_W'(duty_prod[DUTY_DIV_BITS-1:0]) + DUTY_R_W'(q0);
    if (r0 >= DUTY_R_W'(DUTY_DIV)) begin
      q1 = q0 + DUTY_QX_W'(1);
      r1 = r0 - DUTY_R_W'(DUTY_DIV);
    end else begin
      q1 = q0;
      r1 = r0;
    end
    if (r1 >= DUTY_R_W'(DUTY_DIV)) begin
      q2 = q1 + DUTY_QX_W'(1);
    end else begin
      q2 = q1;
    end
    if (q2 > DUTY_QX_W'(DUTY_MAX)) begin
      duty_val = DUTY_W'(DUTY_MAX);
    end else begin
      duty_val = q2[DUTY_W-1:0];
    end
  end

  // Output register: parts the result side from the filter work.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      results.filtered <= filt_sat;
      results.pwm_duty <= duty_val;
    end
  end

  assign results.valid = out_valid;

endmodule

// File: tb/sv/fir21s_tb_pkg.sv
// Prediction and checking for the selectable 21-tap FIR filter testbench.
// Depends on fir21s_pkg for the sample type and the coefficient set names.
package fir21s_tb_pkg;
  import fir21s_pkg::*;

  localparam int N_TAPS   = 21;
  localparam int DUTY_NUM = 333;
  localparam int DUTY_DEN = 4095;
  localparam int DUTY_CAP = 511;
  localparam longint FILT_HI = 64'sd1073741823;
  localparam longint FILT_LO = -64'sd1073741824;

  // Q.14 tap weights; the band-pass set reuses the initial weights.
  localparam int W_INITIAL [N_TAPS] = '{
    0, -118, -371, -765, -1296, -1944, -2679, -3463, -4247, -4979, 56106,
    -4979, -4247, -3463, -2679, -1944, -1296, -765, -371, -118, 0
  };
  localparam int W_HIGHPASS [N_TAPS] = '{
    0, 0, 0, 0, 0, -5, -44, -213, -635, -1205, 14895,
    -1205, -635, -213, -44, -5, 0, 0, 0, 0, 0
  };
  localparam int W_BANDREJECT [N_TAPS] = '{
    0, 3, 27, 102, 268, 561, 982, 1488, 1981, 2344, 2478,
    2344, 1981, 1488, 982, 561, 268, 102, 27, 3, 0
  };

  typedef struct {
    logic signed [30:0] filtered;
    logic [8:0]         pwm_duty;
  } fir_outcome_t;

  class fir_result_book;
    sample_t      window [N_TAPS];
    coef_set_t    active_set;
    fir_outcome_t due_results [$];
    int           mismatches;

    function new();
      foreach (window[k]) window[k] = '0;
      active_set = SET_INITIAL;
      mismatches = 0;
    endfunction

    function void take_setting(coef_set_t s);
      active_set = s;
    endfunction

    function int tap_weight(int k);
      case (active_set)
        SET_HIGHPASS:   return W_HIGHPASS[k];
        SET_BANDREJECT: return W_BANDREJECT[k];
        default:        return W_INITIAL[k];
      endcase
    endfunction

    // The sum covers the window as it stood before this sample is shifted in.
    function void take_sample(sample_t s);
      longint       acc;
      int unsigned  duty;
      fir_outcome_t o;
      acc = 0;
      for (int k = 0; k < N_TAPS; k++)
        acc += longint'(tap_weight(k)) * longint'({1'b0, window[k]});
      if (acc > FILT_HI) acc = FILT_HI;
      if (acc < FILT_LO) acc = FILT_LO;
      o.filtered = acc[30:0];
      duty = (32'(s) * DUTY_NUM) / DUTY_DEN;
      if (duty > DUTY_CAP) duty = DUTY_CAP;
      o.pwm_duty = duty[8:0];
      for (int k = N_TAPS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = s;
      due_results.push_back(o);
    endfunction

    function void match_result(logic signed [30:0] filtered, logic [8:0] pwm_duty);
      fir_outcome_t o;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result filtered=%0d pwm_duty=%0d",
                 $time, filtered, pwm_duty);
        return;
      end
      o = due_results.pop_front();
      if (filtered !== o.filtered) begin
        mismatches++;
        $display("%0t: filtered expected %0d actual %0d", $time, o.filtered, filtered);
      end
      if (pwm_duty !== o.pwm_duty) begin
        mismatches++;
        $display("%0t: pwm_duty expected %0d actual %0d", $time, o.pwm_duty, pwm_duty);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level testbench of the selectable 21-tap FIR filter: drives samples and
// coefficient set writes, and checks every result against a predicted window.
// Depends on fir21s_pkg, fir21s_tb_pkg, the channel interfaces and the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fir21s_pkg::*;
  import fir21s_tb_pkg::*;

  // Cycles with no request on any channel before the run is declared hung.
  // Random gaps and settle pauses add little to the quiet time between requests.
  localparam int HANG_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 150;
  localparam int IDLE_PCT      = 28;

  logic clk;
  logic rst;
  // When low, neither side inserts idle cycles.
  bit   pace_gaps = 1'b1;

  fir21s_sample_if  sample_ch ();
  fir21s_result_if  result_ch ();
  fir21s_setting_if setting_ch ();

  fir_result_book book = new();

  fir_filter_21tap_selectable dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .setting (setting_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one sample, optionally after a few idle cycles, and records it in the
  // predictor at the edge where the request is taken. Valid stays high after the
  // request so that back-to-back samples never lower and raise it in one step.
  task automatic send_sample(input sample_t s);
    while (pace_gaps && $urandom_range(99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    book.take_sample(s);
  endtask

  // Drops the sample valid, waits until every predicted result has come back,
  // then lets the pipeline drain a little further before a register write.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input coef_set_t v);
    setting_ch.valid           <= 1'b1;
    setting_ch.coefficient_set <= v;
    @(posedge clk);
    while (!setting_ch.ready) @(posedge clk);
    book.take_setting(v);
    setting_ch.valid <= 1'b0;
  endtask

  // Result side: a request is taken at an edge where valid and ready were both
  // high before the edge. Ready is then redrawn for the next cycle.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        book.match_result(result_ch.filtered, result_ch.pwm_duty);
      result_ch.ready <= !pace_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: counts consecutive cycles in which no channel moves a request.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (setting_ch.valid && setting_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("fir_filter_21tap_selectable test failed");
    $finish;
  end

  initial begin
    coef_set_t pick;
    sample_t   s;
    sample_t   level;
    int        style;

    sample_ch.valid            <= 1'b0;
    sample_ch.sample           <= '0;
    setting_ch.valid           <= 1'b0;
    setting_ch.coefficient_set <= SET_INITIAL;
    rst                        <= 1'b1;
    level = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset coefficient set. A full-scale impulse
    // followed by 21 zeros walks every tap weight through the output, the next
    // sample showing the window empty again. Then small, mid and full samples.
    send_sample(12'hFFF);
    repeat (21) send_sample('0);
    send_sample(12'h001);
    send_sample(12'h800);
    send_sample(12'hFFF);

    // Random phases. Each one starts from an idle block with a fresh coefficient
    // set; the first four visit every set, including both ends of the range.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       pick = SET_BANDREJECT;
        1:       pick = SET_HIGHPASS;
        2:       pick = SET_BANDPASS;
        3:       pick = SET_INITIAL;
        default: pick = coef_set_t'($urandom_range(3));
      endcase
      write_setting(pick);
      // Two phases in the middle run with no idle cycles on either side.
      pace_gaps = !(p == 5 || p == 6);
      style = $urandom_range(3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // A tenth of the samples are plain noise whatever the phase style.
        if ($urandom_range(9) == 0) begin
          s = sample_t'($urandom_range(4095));
        end else begin
          case (style)
            0: s = sample_t'($urandom_range(4095));
            // Only the two rails, which drives the sum toward its largest values.
            1: s = $urandom_range(1) ? 12'hFFF : 12'h000;
            // Held levels fill the window with one value, a DC step response.
            2: begin
              if ($urandom_range(29) == 0) level = sample_t'($urandom_range(4095));
              s = level;
            end
            // Single bits and tiny values exercise each bit on its own.
            default: s = $urandom_range(1) ? sample_t'(1) << $urandom_range(11)
                                           : sample_t'($urandom_range(15));
          endcase
        end
        send_sample(s);
      end
    end

    pace_gaps = 1'b1;
    settle();
    if (book.mismatches == 0 && book.pending() == 0)
      $display("fir_filter_21tap_selectable test passed");
    else
      $display("fir_filter_21tap_selectable test failed");
    $finish;
  end

endmodule

// File: sim.f
sv/fir21s_pkg.sv
sv/fir21s_sample_if.sv
sv/fir21s_result_if.sv
sv/fir21s_setting_if.sv
sv/fir21s_cell.sv
sv/fir21s_mac.sv
sv/fir_filter_21tap_selectable.sv
tb/sv/fir21s_tb_pkg.sv
tb/sv/tb_top.sv
